@@ rtl/i2cmb_pkg.sv @@
`timescale 1ns / 1ps

package i2cmb_pkg;

  // Default store depths
  localparam int REQUEST_DEPTH_DEF  = 256;
  localparam int RESPONSE_DEPTH_DEF = 256;

  // Field widths
  localparam int DATA_W      = 8;
  localparam int OP_W        = 3;
  localparam int LEN_W       = 9;
  localparam int TIMEOUT_W   = 16;
  localparam int CFG_IDX_W   = 3;
  localparam int NUM_TIMEOUTS = 6;
  localparam int OUT_TDATA_W = 32;

  // Character codes
  localparam logic [DATA_W-1:0] START_MARK = 8'h01;
  localparam logic [DATA_W-1:0] CH_CR      = 8'h0D;
  localparam logic [DATA_W-1:0] CH_LF      = 8'h0A;
  localparam logic [DATA_W-1:0] CH_TAB     = 8'h09;
  localparam logic [DATA_W-1:0] CH_PLUS    = 8'h2B;
  localparam logic [DATA_W-1:0] CH_SPACE   = 8'h20;
  localparam logic [DATA_W-1:0] CH_NUL     = 8'h00;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_BUFFERING = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_MSG       = 3'd5;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH  = 3'd0,
    OP_END   = 3'd1,
    OP_READ  = 3'd2,
    OP_WRITE = 3'd3,
    OP_TAKE  = 3'd4,
    OP_TICK  = 3'd5,
    OP_RESET = 3'd6
  } op_t;

  typedef enum logic [2:0] {
    MODE_IDLE      = 3'd0,
    MODE_BUFFERING = 3'd1,
    MODE_TXREADY   = 3'd2,
    MODE_TX        = 3'd3,
    MODE_WAIT      = 3'd4,
    MODE_RX        = 3'd5,
    MODE_MSG       = 3'd6
  } mode_t;

  // Where the returned byte of a word comes from
  typedef enum logic [1:0] {
    SRC_NONE  = 2'd0,
    SRC_START = 2'd1,
    SRC_REQ   = 2'd2,
    SRC_RSP   = 2'd3
  } src_t;

  // Status of one word after its step
  typedef struct packed {
    logic             accepted;
    mode_t            mode;
    logic [LEN_W-1:0] req_len;
    logic [LEN_W-1:0] rsp_len;
    logic             overflow;
    logic             timed_out;
    src_t             src;
  } status_t;

endpackage

@@ rtl/i2cmb_ram.sv @@
`timescale 1ns / 1ps

module i2cmb_ram #(
  parameter int WIDTH = i2cmb_pkg::DATA_W,
  parameter int DEPTH = i2cmb_pkg::REQUEST_DEPTH_DEF,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read, holds while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/i2cmb_ctrl.sv @@
`timescale 1ns / 1ps

module i2cmb_ctrl #(
  parameter int REQUEST_DEPTH  = i2cmb_pkg::REQUEST_DEPTH_DEF,
  parameter int RESPONSE_DEPTH = i2cmb_pkg::RESPONSE_DEPTH_DEF,
  localparam int REQ_AW = $clog2(REQUEST_DEPTH),
  localparam int RSP_AW = $clog2(RESPONSE_DEPTH)
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              step,
  input  logic [i2cmb_pkg::OP_W-1:0]        op,
  input  logic [i2cmb_pkg::DATA_W-1:0]      data,
  input  logic                              cfg_we,
  input  logic [i2cmb_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [i2cmb_pkg::TIMEOUT_W-1:0]   cfg_data,
  output i2cmb_pkg::status_t                status,
  output logic                              req_we,
  output logic [REQ_AW-1:0]                 req_waddr,
  output logic [i2cmb_pkg::DATA_W-1:0]      req_wdata,
  output logic                              req_re,
  output logic [REQ_AW-1:0]                 req_raddr,
  output logic                              rsp_we,
  output logic [RSP_AW-1:0]                 rsp_waddr,
  output logic [i2cmb_pkg::DATA_W-1:0]      rsp_wdata,
  output logic                              rsp_re,
  output logic [RSP_AW-1:0]                 rsp_raddr
);

  import i2cmb_pkg::*;

  localparam int REQ_FW = $clog2(REQUEST_DEPTH + 1);
  localparam int RSP_FW = $clog2(RESPONSE_DEPTH + 1);
  localparam logic [REQ_FW-1:0] REQ_MAX = REQ_FW'(REQUEST_DEPTH);
  localparam logic [RSP_FW-1:0] RSP_MAX = RSP_FW'(RESPONSE_DEPTH);

  mode_t                mode, mode_next;
  logic [REQ_FW-1:0]    req_fill, req_fill_next;
  logic [REQ_FW-1:0]    req_pos, req_pos_next;
  logic [RSP_FW-1:0]    rsp_fill, rsp_fill_next;
  logic [RSP_FW-1:0]    rsp_pos, rsp_pos_next;
  logic [TIMEOUT_W-1:0] elapsed, elapsed_next;
  logic                 ovf, ovf_next;
  logic [TIMEOUT_W-1:0] timeouts [NUM_TIMEOUTS];

  op_t                  op_code;
  logic [REQ_FW-1:0]    eff_fill;
  logic [2:0]           tidx;
  logic [TIMEOUT_W-1:0] limit;
  logic [DATA_W-1:0]    mapped;
  logic                 go_idle;
  logic                 acc, tmo;
  logic                 req_we_c, req_re_c, rsp_we_c, rsp_re_c;
  src_t                 src;

  assign op_code = op_t'(op);

  // Timeout registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_TIMEOUTS; i++) begin
        timeouts[i] <= '0;
      end
    end else if (cfg_we && cfg_index <= REG_TIMEOUT_MSG) begin
      timeouts[cfg_index] <= cfg_data;
    end
  end

  // Entry 0 of the request store is never written (its place in the output is
  // taken by the start marker); a push or end from idle lands at entry 1.
  assign eff_fill = (mode == MODE_IDLE) ? REQ_FW'(1) : req_fill;

  assign tidx  = 3'(mode) - 3'd1;
  assign limit = (mode != MODE_IDLE && tidx <= REG_TIMEOUT_MSG) ? timeouts[tidx] : '0;

  assign mapped = (data == CH_PLUS) ? CH_SPACE :
                  (data == CH_NUL)  ? CH_TAB   : data;

  // Next state
  always_comb begin
    mode_next     = mode;
    req_fill_next = req_fill;
    req_pos_next  = req_pos;
    rsp_fill_next = rsp_fill;
    rsp_pos_next  = rsp_pos;
    elapsed_next  = elapsed;
    ovf_next      = ovf;
    go_idle       = 1'b0;
    acc           = 1'b0;
    tmo           = 1'b0;
    src           = SRC_NONE;
    req_we_c      = 1'b0;
    req_re_c      = 1'b0;
    rsp_we_c      = 1'b0;
    rsp_re_c      = 1'b0;

    case (op_code)
      OP_PUSH, OP_END: begin
        if (mode == MODE_IDLE || mode == MODE_BUFFERING) begin
          acc = 1'b1;
          if (mode == MODE_IDLE) begin
            elapsed_next = '0;
          end
          if (eff_fill < REQ_MAX) begin
            req_we_c      = 1'b1;
            req_fill_next = eff_fill + REQ_FW'(1);
          end else begin
            ovf_next = 1'b1;
          end
          if (op_code == OP_END) begin
            mode_next    = MODE_TXREADY;
            elapsed_next = '0;
          end else begin
            mode_next = MODE_BUFFERING;
          end
        end
      end
      OP_READ: begin
        if (mode == MODE_TXREADY || mode == MODE_TX) begin
          mode_next = MODE_TX;
          if (mode == MODE_TXREADY) begin
            elapsed_next = '0;
          end
          if (req_pos < req_fill) begin
            req_re_c     = 1'b1;
            src          = (req_pos == '0) ? SRC_START : SRC_REQ;
            req_pos_next = req_pos + REQ_FW'(1);
          end
          if (req_pos_next >= req_fill) begin
            mode_next    = MODE_WAIT;
            elapsed_next = '0;
          end
        end
      end
      OP_WRITE: begin
        if (mode == MODE_WAIT || mode == MODE_RX) begin
          mode_next = MODE_RX;
          if (mode == MODE_WAIT) begin
            elapsed_next = '0;
          end
          if (data == CH_CR) begin
            mode_next    = MODE_MSG;
            elapsed_next = '0;
          end else if (data != CH_LF) begin
            if (rsp_fill < RSP_MAX) begin
              rsp_we_c      = 1'b1;
              rsp_fill_next = rsp_fill + RSP_FW'(1);
            end else begin
              ovf_next = 1'b1;
            end
          end
        end
      end
      OP_TAKE: begin
        if (mode == MODE_MSG) begin
          if (rsp_pos < rsp_fill) begin
            rsp_re_c     = 1'b1;
            src          = SRC_RSP;
            rsp_pos_next = rsp_pos + RSP_FW'(1);
          end
          if (rsp_pos_next >= rsp_fill) begin
            go_idle = 1'b1;
          end
        end
      end
      OP_TICK: begin
        if (mode != MODE_IDLE) begin
          if (limit != '0 && elapsed >= limit) begin
            go_idle = 1'b1;
            tmo     = 1'b1;
          end else if (elapsed != {TIMEOUT_W{1'b1}}) begin
            elapsed_next = elapsed + TIMEOUT_W'(1);
          end
        end
      end
      OP_RESET: begin
        go_idle  = 1'b1;
        ovf_next = 1'b0;
      end
      default: begin
      end
    endcase

    // Entering idle clears counts and positions
    if (go_idle) begin
      mode_next     = MODE_IDLE;
      req_fill_next = '0;
      req_pos_next  = '0;
      rsp_fill_next = '0;
      rsp_pos_next  = '0;
      elapsed_next  = '0;
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      mode     <= MODE_IDLE;
      req_fill <= '0;
      req_pos  <= '0;
      rsp_fill <= '0;
      rsp_pos  <= '0;
      elapsed  <= '0;
      ovf      <= 1'b0;
    end else if (step) begin
      mode     <= mode_next;
      req_fill <= req_fill_next;
      req_pos  <= req_pos_next;
      rsp_fill <= rsp_fill_next;
      rsp_pos  <= rsp_pos_next;
      elapsed  <= elapsed_next;
      ovf      <= ovf_next;
    end
  end

  // Memory ports
  assign req_we    = step & req_we_c;
  assign req_waddr = eff_fill[REQ_AW-1:0];
  assign req_wdata = (op_code == OP_END) ? CH_CR : mapped;
  assign req_re    = step & req_re_c;
  assign req_raddr = req_pos[REQ_AW-1:0];
  assign rsp_we    = step & rsp_we_c;
  assign rsp_waddr = rsp_fill[RSP_AW-1:0];
  assign rsp_wdata = data;
  assign rsp_re    = step & rsp_re_c;
  assign rsp_raddr = rsp_pos[RSP_AW-1:0];

  // Status after the step
  always_comb begin
    status.accepted  = acc;
    status.mode      = mode_next;
    status.req_len   = LEN_W'(req_fill_next);
    status.rsp_len   = LEN_W'(rsp_fill_next);
    status.overflow  = ovf_next;
    status.timed_out = tmo;
    status.src       = src;
  end

  // Start marker entry is never overwritten
  a_no_mark_write: assert property (@(posedge clk) disable iff (rst)
    req_we |-> req_waddr != '0)
    else $error("request entry 0 written");

  // Idle implies empty stores
  a_idle_empty: assert property (@(posedge clk) disable iff (rst)
    mode == MODE_IDLE |-> (req_fill == '0 && rsp_fill == '0 &&
                           req_pos == '0 && rsp_pos == '0))
    else $error("idle with nonzero counts");

  // Read positions never pass fills
  a_pos_bound: assert property (@(posedge clk) disable iff (rst)
    req_pos <= req_fill && rsp_pos <= rsp_fill)
    else $error("read position beyond fill");

  // Reset opcode leaves idle with overflow cleared
  a_reset_op: assert property (@(posedge clk) disable iff (rst)
    step && op_code == OP_RESET |=> mode == MODE_IDLE && !ovf)
    else $error("reset opcode not honored");

endmodule

@@ rtl/i2c_slave_message_bridge_unit.sv @@
`timescale 1ns / 1ps
// Host / I2C master message bridge.
// Input channel s_*: one word per operation. s_tuser carries the opcode
// (push byte, end request, bus read, bus write, host take, tick, reset),
// s_tdata carries the byte that goes with push or bus write.
// Output channel m_*: one result word per input word, in order: the byte
// returned to the master or host, the accepted flag, the mode after the
// step, both buffer fill counts, the sticky overflow flag and a timeout flag.
// Configuration: cfg_we writes cfg_data into timeout register cfg_index
// (0 buffering, 1 txready, 2 tx, 3 wait, 4 rx, 5 msg); write only while idle.
// Throughput: one word per cycle while the output is not stalled. Each store
// is one RAM with one write and one read port, and each word does at most one
// access to each store. A result is built from the RAM read data and the
// status held in stage 1, and then waits in the output register.
// Reset (rst, synchronous): idle, counts cleared, timeouts zero; no clearing
// pass is needed, store data is used only where written.
// When m_tready is low, one result waits in the output register and one in
// the stage behind it; s_tready then drops until the output moves.
module i2c_slave_message_bridge_unit #(
  parameter int REQUEST_DEPTH  = i2cmb_pkg::REQUEST_DEPTH_DEF,
  parameter int RESPONSE_DEPTH = i2cmb_pkg::RESPONSE_DEPTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  // [7:0] data_byte
  input  logic [i2cmb_pkg::DATA_W-1:0]         s_tdata,
  // [2:0] opcode
  input  logic [i2cmb_pkg::OP_W-1:0]           s_tuser,
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  // [7:0] out_byte, [8] accepted, [11:9] mode, [20:12] request_length,
  // [29:21] response_length, [30] overflow, [31] timed_out
  output logic [i2cmb_pkg::OUT_TDATA_W-1:0]    m_tdata,
  input  logic                                 cfg_we,
  input  logic [i2cmb_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [i2cmb_pkg::TIMEOUT_W-1:0]      cfg_data
);

  import i2cmb_pkg::*;

  localparam int REQ_AW = $clog2(REQUEST_DEPTH);
  localparam int RSP_AW = $clog2(RESPONSE_DEPTH);

  status_t            status, s1_status;
  logic               step, s1_valid, s1_move;
  logic               req_we, req_re, rsp_we, rsp_re;
  logic [REQ_AW-1:0]  req_waddr, req_raddr;
  logic [RSP_AW-1:0]  rsp_waddr, rsp_raddr;
  logic [DATA_W-1:0]  req_wdata, rsp_wdata, req_rdata, rsp_rdata;
  logic [DATA_W-1:0]  out_byte;

  // Handshake
  assign s1_move  = !m_tvalid || m_tready;
  assign s_tready = !s1_valid || s1_move;
  assign step     = s_tvalid && s_tready;

  i2cmb_ctrl #(
    .REQUEST_DEPTH  (REQUEST_DEPTH),
    .RESPONSE_DEPTH (RESPONSE_DEPTH)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .op        (s_tuser),
    .data      (s_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .status    (status),
    .req_we    (req_we),
    .req_waddr (req_waddr),
    .req_wdata (req_wdata),
    .req_re    (req_re),
    .req_raddr (req_raddr),
    .rsp_we    (rsp_we),
    .rsp_waddr (rsp_waddr),
    .rsp_wdata (rsp_wdata),
    .rsp_re    (rsp_re),
    .rsp_raddr (rsp_raddr)
  );

  i2cmb_ram #(
    .WIDTH (DATA_W),
    .DEPTH (REQUEST_DEPTH)
  ) u_req_ram (
    .clk   (clk),
    .we    (req_we),
    .waddr (req_waddr),
    .wdata (req_wdata),
    .re    (req_re),
    .raddr (req_raddr),
    .rdata (req_rdata)
  );

  i2cmb_ram #(
    .WIDTH (DATA_W),
    .DEPTH (RESPONSE_DEPTH)
  ) u_rsp_ram (
    .clk   (clk),
    .we    (rsp_we),
    .waddr (rsp_waddr),
    .wdata (rsp_wdata),
    .re    (rsp_re),
    .raddr (rsp_raddr),
    .rdata (rsp_rdata)
  );

  // Stage 1: status waits here while the RAM read completes
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_tready) begin
      s1_valid <= step;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      s1_status <= status;
    end
  end

  // Returned byte select
  always_comb begin
    case (s1_status.src)
      SRC_START: out_byte = START_MARK;
      SRC_REQ:   out_byte = req_rdata;
      SRC_RSP:   out_byte = rsp_rdata;
      default:   out_byte = '0;
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s1_move) begin
      m_tvalid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move && s1_valid) begin
      m_tdata <= {s1_status.timed_out, s1_status.overflow, s1_status.rsp_len,
                  s1_status.req_len, s1_status.mode, s1_status.accepted, out_byte};
    end
  end

endmodule

@@ bench/bridge_result_checker.sv @@
`timescale 1ns / 1ps

// Watches both streams and the config port, predicts the status word for
// every accepted input word and compares it with what the bridge returns.
module bridge_result_checker #(
  parameter int REQUEST_DEPTH  = i2cmb_pkg::REQUEST_DEPTH_DEF,
  parameter int RESPONSE_DEPTH = i2cmb_pkg::RESPONSE_DEPTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_tvalid,
  input  logic                                 s_tready,
  input  logic [i2cmb_pkg::DATA_W-1:0]         s_tdata,
  input  logic [i2cmb_pkg::OP_W-1:0]           s_tuser,
  input  logic                                 m_tvalid,
  input  logic                                 m_tready,
  input  logic [i2cmb_pkg::OUT_TDATA_W-1:0]    m_tdata,
  input  logic                                 cfg_we,
  input  logic [i2cmb_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [i2cmb_pkg::TIMEOUT_W-1:0]      cfg_data,
  output int                                   mismatch_count,
  output int                                   pending_count
);
  import i2cmb_pkg::*;

  // Result word layout, MSB first, matching m_tdata
  typedef struct packed {
    logic              timed_out;
    logic              overflow;
    logic [LEN_W-1:0]  rsp_len;
    logic [LEN_W-1:0]  req_len;
    mode_t             mode;
    logic              accepted;
    logic [DATA_W-1:0] out_byte;
  } bridge_status_t;

  // Shadow state of the bridge
  mode_t                cur_mode;
  logic [DATA_W-1:0]    req_mem [REQUEST_DEPTH];
  logic [DATA_W-1:0]    rsp_mem [RESPONSE_DEPTH];
  int unsigned          req_fill, req_rd, rsp_fill, rsp_rd;
  int unsigned          elapsed;
  logic                 ovf_flag;
  logic [TIMEOUT_W-1:0] tmo_limit [NUM_TIMEOUTS];

  bridge_status_t expected_status_q [$];
  bridge_status_t want, got;
  int             fail_total = 0;

  assign mismatch_count = fail_total;

  function automatic void go_to_mode(input mode_t m);
    cur_mode = m;
    elapsed  = 0;
    if (m == MODE_IDLE) begin
      req_fill = 0;
      req_rd   = 0;
      rsp_fill = 0;
      rsp_rd   = 0;
    end
  endfunction

  function automatic void store_request(input logic [DATA_W-1:0] b);
    if (req_fill < REQUEST_DEPTH) begin
      req_mem[req_fill] = b;
      req_fill++;
    end else begin
      ovf_flag = 1'b1;
    end
  endfunction

  function automatic void store_response(input logic [DATA_W-1:0] b);
    if (rsp_fill < RESPONSE_DEPTH) begin
      rsp_mem[rsp_fill] = b;
      rsp_fill++;
    end else begin
      ovf_flag = 1'b1;
    end
  endfunction

  // One input word through the bridge; returns the status it reports
  function automatic bridge_status_t step_bridge(input logic [OP_W-1:0] op,
                                                 input logic [DATA_W-1:0] d);
    bridge_status_t       r;
    logic [DATA_W-1:0]    b;
    logic [TIMEOUT_W-1:0] limit;
    r = '0;
    case (op)
      OP_PUSH, OP_END: begin
        // first push or bare end opens a request with the start marker
        if (cur_mode == MODE_IDLE) begin
          go_to_mode(MODE_BUFFERING);
          store_request(START_MARK);
        end
        if (cur_mode == MODE_BUFFERING) begin
          if (op == OP_END) begin
            store_request(CH_CR);
            go_to_mode(MODE_TXREADY);
          end else begin
            b = (d == CH_PLUS) ? CH_SPACE : (d == CH_NUL) ? CH_TAB : d;
            store_request(b);
          end
          r.accepted = 1'b1;
        end
      end
      OP_READ: begin
        if (cur_mode == MODE_TXREADY) go_to_mode(MODE_TX);
        if (cur_mode == MODE_TX) begin
          if (req_rd < req_fill && req_rd < REQUEST_DEPTH) begin
            r.out_byte = req_mem[req_rd];
            req_rd++;
          end
          if (req_rd >= req_fill) go_to_mode(MODE_WAIT);
        end
      end
      OP_WRITE: begin
        if (cur_mode == MODE_WAIT) go_to_mode(MODE_RX);
        if (cur_mode == MODE_RX) begin
          if (d == CH_CR) go_to_mode(MODE_MSG);
          else if (d != CH_LF) store_response(d);
        end
      end
      OP_TAKE: begin
        if (cur_mode == MODE_MSG) begin
          if (rsp_rd < rsp_fill && rsp_rd < RESPONSE_DEPTH) begin
            r.out_byte = rsp_mem[rsp_rd];
            rsp_rd++;
          end
          if (rsp_rd >= rsp_fill) go_to_mode(MODE_IDLE);
        end
      end
      OP_TICK: begin
        // per-mode idle timeout, elapsed count saturates
        if (cur_mode != MODE_IDLE) begin
          limit = tmo_limit[int'(cur_mode) - 1];
          if (limit != 0 && elapsed >= limit) begin
            go_to_mode(MODE_IDLE);
            r.timed_out = 1'b1;
          end else if (elapsed < 32'hFFFF) begin
            elapsed++;
          end
        end
      end
      OP_RESET: begin
        go_to_mode(MODE_IDLE);
        ovf_flag = 1'b0;
      end
      default: ;
    endcase
    r.mode     = cur_mode;
    r.req_len  = req_fill[LEN_W-1:0];
    r.rsp_len  = rsp_fill[LEN_W-1:0];
    r.overflow = ovf_flag;
    return r;
  endfunction

  function automatic void compare_field(input string name, input int unsigned exp_v,
                                        input int unsigned act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h", $time, name, exp_v,
               act_v);
      fail_total++;
    end
  endfunction

  // Config writes, input words and result words in edge order
  always @(posedge clk) begin
    if (rst) begin
      foreach (tmo_limit[i]) tmo_limit[i] = '0;
      go_to_mode(MODE_IDLE);
      ovf_flag = 1'b0;
      expected_status_q.delete();
    end else begin
      if (cfg_we && cfg_index < NUM_TIMEOUTS) tmo_limit[cfg_index] = cfg_data;
      if (s_tvalid && s_tready) expected_status_q.push_back(step_bridge(s_tuser, s_tdata));
      if (m_tvalid && m_tready) begin
        if (expected_status_q.size() == 0) begin
          $display("%0t: unexpected word: expected none, actual 0x%08h", $time,
                   m_tdata);
          fail_total++;
        end else begin
          want = expected_status_q.pop_front();
          got  = bridge_status_t'(m_tdata);
          compare_field("out_byte", want.out_byte, got.out_byte);
          compare_field("accepted", want.accepted, got.accepted);
          compare_field("mode", int'(want.mode), int'(got.mode));
          compare_field("request_length", want.req_len, got.req_len);
          compare_field("response_length", want.rsp_len, got.rsp_len);
          compare_field("overflow", want.overflow, got.overflow);
          compare_field("timed_out", want.timed_out, got.timed_out);
        end
      end
    end
    pending_count <= expected_status_q.size();
  end

endmodule

@@ bench/tb.sv @@
`timescale 1ns / 1ps

module tb;
  import i2cmb_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED = 3'd7;
  localparam int STALL_LIMIT  = 5000;
  localparam int DRAIN_CYCLES = 6;
  localparam int LONG_HOLD    = 300;

  logic                   clk       = 1'b0;
  logic                   rst       = 1'b1;
  logic                   s_tvalid  = 1'b0;
  logic                   s_tready;
  logic [DATA_W-1:0]      s_tdata   = '0;
  logic [OP_W-1:0]        s_tuser   = '0;
  logic                   m_tvalid;
  logic                   m_tready  = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic                   cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [TIMEOUT_W-1:0]   cfg_data  = '0;

  int mismatch_count;
  int pending_count;
  int words_sent  = 0;
  int burst_left  = 0;
  int idle_cycles = 0;
  bit hold_done   = 1'b0;

  always #5 clk = ~clk;

  i2c_slave_message_bridge_unit i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  bridge_result_checker i_checker (
    .clk            (clk),
    .rst            (rst),
    .s_tvalid       (s_tvalid),
    .s_tready       (s_tready),
    .s_tdata        (s_tdata),
    .s_tuser        (s_tuser),
    .m_tvalid       (m_tvalid),
    .m_tready       (m_tready),
    .m_tdata        (m_tdata),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .mismatch_count (mismatch_count),
    .pending_count  (pending_count)
  );

  // Any byte value
  function automatic logic [DATA_W-1:0] rand_byte();
    return DATA_W'($urandom_range(0, 255));
  endfunction

  // Offer one word, in bursts with random gaps between them
  task automatic send_word(input logic [OP_W-1:0] op, input logic [DATA_W-1:0] d);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 10);
      if (gap != 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= d;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    words_sent++;
  endtask

  // Random ticks ahead of a word
  task automatic send_ticked(input logic [OP_W-1:0] op, input logic [DATA_W-1:0] d,
                             input int tick_pct);
    if ($urandom_range(0, 99) < tick_pct)
      repeat ($urandom_range(1, 4)) send_word(OP_TICK, rand_byte());
    send_word(op, d);
  endtask

  // Stop offering and wait until every result is back
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Park the bridge in idle, then load all timeouts from [lo, hi]
  task automatic set_timeouts(input int lo, input int hi);
    send_word(OP_RESET, rand_byte());
    drain();
    for (int r = REG_TIMEOUT_BUFFERING; r <= REG_TIMEOUT_MSG; r++) begin
      cfg_we    <= 1'b1;
      cfg_index <= CFG_IDX_W'(r);
      cfg_data  <= TIMEOUT_W'($urandom_range(lo, hi));
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  function automatic logic [DATA_W-1:0] request_byte();
    case ($urandom_range(0, 9))
      0:       return CH_PLUS;
      1:       return CH_NUL;
      2:       return ($urandom_range(0, 1) != 0) ? CH_CR : 8'hFF;
      3:       return ($urandom_range(0, 1) != 0) ? CH_LF : START_MARK;
      default: return rand_byte();
    endcase
  endfunction

  // Any byte but CR; LF now and then
  function automatic logic [DATA_W-1:0] response_byte();
    logic [DATA_W-1:0] b;
    b = ($urandom_range(0, 7) == 0) ? CH_LF : 8'($urandom_range(0, 255));
    return (b == CH_CR) ? 8'hFF : b;
  endfunction

  // Full request / response round trip
  task automatic exchange(input int n_req, input int n_rsp, input int tick_pct);
    int                kept;
    logic [DATA_W-1:0] b;
    kept = 0;
    if ($urandom_range(0, 9) == 0) send_word(OP_RESET, rand_byte());
    repeat (n_req) send_ticked(OP_PUSH, request_byte(), tick_pct);
    send_ticked(OP_END, rand_byte(), tick_pct);
    repeat (n_req + 2 + $urandom_range(0, 1))
      send_ticked(OP_READ, rand_byte(), tick_pct);
    repeat (n_rsp) begin
      b = response_byte();
      if (b != CH_LF) kept++;
      send_ticked(OP_WRITE, b, tick_pct);
    end
    send_ticked(OP_WRITE, CH_CR, tick_pct);
    repeat (((kept == 0) ? 1 : kept) + $urandom_range(0, 1))
      send_ticked(OP_TAKE, rand_byte(), tick_pct);
  endtask

  // Round trip cut short at a random point
  task automatic broken_exchange(input int tick_pct);
    int stage;
    stage = $urandom_range(0, 3);
    repeat ($urandom_range(0, 4)) send_ticked(OP_PUSH, request_byte(), tick_pct);
    if (stage >= 1) send_ticked(OP_END, rand_byte(), tick_pct);
    if (stage >= 2)
      repeat ($urandom_range(1, 4)) send_ticked(OP_READ, rand_byte(), tick_pct);
    if (stage >= 3)
      repeat ($urandom_range(1, 4)) send_ticked(OP_WRITE, response_byte(), tick_pct);
    if ($urandom_range(0, 9) < 7) send_word(OP_RESET, rand_byte());
  endtask

  task automatic run_random(input int upto, input int tick_pct);
    int sel;
    while (words_sent < upto) begin
      sel = $urandom_range(0, 99);
      if (sel < 75) begin
        exchange($urandom_range(0, ($urandom_range(0, 4) == 0) ? 24 : 5),
                 $urandom_range(0, ($urandom_range(0, 4) == 0) ? 24 : 5), tick_pct);
      end else if (sel < 88) begin
        broken_exchange(tick_pct);
      end else begin
        repeat ($urandom_range(1, 4))
          send_word(OP_W'($urandom_range(0, 7)), rand_byte());
        if ($urandom_range(0, 1) != 0) send_word(OP_RESET, rand_byte());
      end
    end
  endtask

  // Stimulus and verdict
  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    set_timeouts(0, 0);
    // idle-mode commands that do nothing
    send_word(OP_READ, 8'hA5);
    send_word(OP_TAKE, 8'h5A);
    send_word(OP_WRITE, 8'h55);
    send_word(OP_TICK, 8'h00);
    send_word(OP_UNUSED, 8'hFF);
    // empty request, then empty response
    send_word(OP_END, 8'h00);
    send_word(OP_PUSH, 8'h41);
    send_word(OP_READ, 8'h00);
    send_word(OP_READ, 8'h00);
    send_word(OP_READ, 8'h00);
    send_word(OP_WRITE, CH_CR);
    send_word(OP_TAKE, 8'h00);
    // character mapping and byte extremes
    send_word(OP_PUSH, CH_PLUS);
    send_word(OP_PUSH, CH_NUL);
    send_word(OP_PUSH, 8'hFF);
    send_word(OP_PUSH, CH_CR);
    send_word(OP_END, 8'hFF);
    repeat (6) send_word(OP_READ, 8'h00);
    // response with LF dropped
    send_word(OP_WRITE, CH_LF);
    send_word(OP_WRITE, 8'h00);
    send_word(OP_WRITE, 8'hFF);
    send_word(OP_WRITE, CH_CR);
    send_word(OP_TAKE, 8'h00);
    send_word(OP_TAKE, 8'h00);
    send_word(OP_RESET, 8'h00);
    run_random(120, 10);

    // longest timeouts; request store overrun, then response store overrun
    set_timeouts(65535, 65535);
    repeat (258) send_word(OP_PUSH, request_byte());
    send_word(OP_END, rand_byte());
    repeat (2) send_word(OP_READ, rand_byte());
    send_word(OP_RESET, rand_byte());
    send_word(OP_PUSH, 8'h41);
    send_word(OP_END, rand_byte());
    repeat (4) send_word(OP_READ, rand_byte());
    repeat (258) send_word(OP_WRITE, 8'h42);
    send_word(OP_WRITE, CH_CR);
    repeat (2) send_word(OP_TAKE, rand_byte());
    send_word(OP_RESET, rand_byte());
    run_random(780, 10);

    // very short timeouts, frequent ticks
    set_timeouts(1, 4);
    run_random(920, 25);

    set_timeouts(0, 12);
    run_random(1040, 15);

    drain();
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Output side: stall patterns and long holds, at least one, while the input keeps coming
  initial begin
    int style;
    int span;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if ((!hold_done && words_sent > 400) || $urandom_range(0, 80) == 0) begin
        hold_done = 1'b1;
        m_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end
      style = $urandom_range(0, 3);
      span  = $urandom_range(10, 80);
      for (int k = 0; k < span; k++) begin
        case (style)
          0:       m_tready <= 1'b1;
          1:       m_tready <= 1'($urandom_range(0, 1));
          2:       m_tready <= (k % 4 != 0);
          default: m_tready <= ($urandom_range(0, 3) == 0);
        endcase
        @(posedge clk);
      end
    end
  end

  // Watchdog: too long without any word moving
  always @(posedge clk) begin
    if (!rst) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= STALL_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

endmodule
